FILE: design/dama_pkg.sv
// ----------------------------------------------------------------------------
// dama_pkg - shared definitions for the dual axis moving average
// Sample, sum and count types, sizing constants, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dama_pkg;

  localparam int MAX_HISTORY = 16;                    // ring depth, 2..256
  localparam int SAMPLE_W    = 16;                    // Q8.8 sample width
  localparam int WIN_W       = 4;                     // window_len register width
  localparam int IDX_W       = $clog2(MAX_HISTORY);   // ring index width
  localparam int CNT_W       = IDX_W + 1;             // held count, 0..MAX_HISTORY
  localparam int SUM_W       = SAMPLE_W + CNT_W;      // running sum width
  localparam int WCMP_W      = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int STEP_W      = $clog2(SUM_W);         // divider step counter

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [WIN_W-1:0]           win_t;
  typedef logic [STEP_W-1:0]          step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_RETIRE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;    // transfer taken: write ring, add to sums
    logic div_load;  // load dividers, read oldest entry
    logic div_step;  // one quotient bit per lane
    logic retire;    // drop oldest sample if window is full
    logic out_load;  // load output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result
  } status_t;

endpackage

FILE: design/dama_pos_if.sv
// ----------------------------------------------------------------------------
// dama_pos_if - position sample channel
// Valid/ready channel carrying one x and one y Q8.8 sample.
// ----------------------------------------------------------------------------
interface dama_pos_if
  import dama_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t pos_x;
  sample_t pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

FILE: design/dama_avg_if.sv
// ----------------------------------------------------------------------------
// dama_avg_if - averaged position channel
// Valid/ready channel carrying one x and one y Q8.8 mean.
// ----------------------------------------------------------------------------
interface dama_avg_if
  import dama_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t avg_x;
  sample_t avg_y;

  modport source (output valid, output avg_x, output avg_y, input ready);
  modport sink   (input valid, input avg_x, input avg_y, output ready);
endinterface

FILE: design/dama_ctrl.sv
// ----------------------------------------------------------------------------
// dama_ctrl - sequencer for the moving average
// Steps each sample through accumulate, divide, retire and output.
// ----------------------------------------------------------------------------
module dama_ctrl
  import dama_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t sts,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == step_t'(SUM_W - 1)) begin
          state_next = S_RETIRE;
        end
      end
      S_RETIRE: begin
        cmd.retire = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_LOAD)
    else $error("accepted sample not followed by divider load");

  a_out_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output loaded while previous result still held");

  a_retire_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.retire |-> $past(state) == S_DIV && $past(step) == step_t'(SUM_W - 1))
    else $error("retire without a full divide");

endmodule

FILE: design/dama_datapath.sv
// ----------------------------------------------------------------------------
// dama_datapath - history ring, running sums and dividers
// Holds the sample ring, both running sums, two restoring divider lanes
// and the output register.
// ----------------------------------------------------------------------------
module dama_datapath
  import dama_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  win_t            cfg_data,
  input  cmd_t            cmd,
  output status_t         sts,
  dama_pos_if.sink        pos,
  dama_avg_if.source      avg
);

  // one restoring step: returns {remainder, quotient}
  function automatic logic [CNT_W+SUM_W-1:0] div_step_f(
    input cnt_t             rem,
    input logic [SUM_W-1:0] quo,
    input cnt_t             dvs
  );
    logic [CNT_W:0] part;
    logic [CNT_W:0] diff;
    part = {rem, quo[SUM_W-1]};
    diff = part - {1'b0, dvs};
    if (!diff[CNT_W]) begin
      div_step_f = {diff[CNT_W-1:0], quo[SUM_W-2:0], 1'b1};
    end else begin
      div_step_f = {part[CNT_W-1:0], quo[SUM_W-2:0], 1'b0};
    end
  endfunction

  logic [2*SAMPLE_W-1:0] ring [MAX_HISTORY];
  logic [2*SAMPLE_W-1:0] old_word;

  win_t window_len;
  idx_t oldest_slot;
  cnt_t held_count;
  sum_t x_sum, y_sum;

  cnt_t             rem_x, rem_y;
  logic [SUM_W-1:0] quo_x, quo_y;
  logic             neg_x, neg_y;

  logic    out_valid;
  sample_t out_x, out_y;

  // write slot: oldest + held, wrapped once
  cnt_t slot_raw;
  idx_t slot;
  assign slot_raw = cnt_t'(oldest_slot) + held_count;
  assign slot = (slot_raw >= cnt_t'(MAX_HISTORY)) ?
                idx_t'(slot_raw - cnt_t'(MAX_HISTORY)) : idx_t'(slot_raw);

  // effective window, clipped to what the ring can keep
  logic [WCMP_W-1:0] win_ext, win_eff;
  assign win_ext = WCMP_W'(window_len);
  assign win_eff = (win_ext > WCMP_W'(MAX_HISTORY - 1)) ?
                   WCMP_W'(MAX_HISTORY - 1) : win_ext;

  logic drop;
  assign drop = WCMP_W'(held_count) > win_eff;

  sum_t sx_ext, sy_ext, ox_ext, oy_ext;
  assign sx_ext = {{(SUM_W-SAMPLE_W){pos.pos_x[SAMPLE_W-1]}}, pos.pos_x};
  assign sy_ext = {{(SUM_W-SAMPLE_W){pos.pos_y[SAMPLE_W-1]}}, pos.pos_y};
  assign ox_ext = {{(SUM_W-SAMPLE_W){old_word[2*SAMPLE_W-1]}},
                   old_word[2*SAMPLE_W-1:SAMPLE_W]};
  assign oy_ext = {{(SUM_W-SAMPLE_W){old_word[SAMPLE_W-1]}},
                   old_word[SAMPLE_W-1:0]};

  // history ring
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[slot] <= {pos.pos_x, pos.pos_y};
    end
    if (cmd.div_load) begin
      old_word <= ring[oldest_slot];
    end
  end

  // window register, ring pointers and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len  <= WINDOW_RESET;
      oldest_slot <= '0;
      held_count  <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
    end else if (cfg_we) begin
      window_len  <= cfg_data;
      oldest_slot <= '0;
      held_count  <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
    end else if (cmd.accept) begin
      held_count <= held_count + 1'b1;
      x_sum      <= x_sum + sx_ext;
      y_sum      <= y_sum + sy_ext;
    end else if (cmd.retire && drop) begin
      held_count  <= held_count - 1'b1;
      x_sum       <= x_sum - ox_ext;
      y_sum       <= y_sum - oy_ext;
      oldest_slot <= (oldest_slot == idx_t'(MAX_HISTORY - 1)) ?
                     '0 : oldest_slot + 1'b1;
    end
  end

  // divider lanes: magnitude divide, sign applied at the end
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_x <= '0;
      rem_y <= '0;
      neg_x <= x_sum[SUM_W-1];
      neg_y <= y_sum[SUM_W-1];
      quo_x <= x_sum[SUM_W-1] ? (~x_sum + 1'b1) : x_sum;
      quo_y <= y_sum[SUM_W-1] ? (~y_sum + 1'b1) : y_sum;
    end else if (cmd.div_step) begin
      {rem_x, quo_x} <= div_step_f(rem_x, quo_x, held_count);
      {rem_y, quo_y} <= div_step_f(rem_y, quo_y, held_count);
    end
  end

  logic [SUM_W-1:0] res_x, res_y;
  assign res_x = neg_x ? (~quo_x + 1'b1) : quo_x;
  assign res_y = neg_y ? (~quo_y + 1'b1) : quo_y;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (avg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x <= res_x[SAMPLE_W-1:0];
      out_y <= res_y[SAMPLE_W-1:0];
    end
  end

  assign avg.valid    = out_valid;
  assign avg.avg_x    = out_x;
  assign avg.avg_y    = out_y;
  assign sts.out_free = !out_valid || avg.ready;

  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> avg.valid)
    else $error("loaded result not presented");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= cnt_t'(MAX_HISTORY) && oldest_slot <= idx_t'(MAX_HISTORY - 1))
    else $error("ring pointers out of range");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> held_count == '0 && x_sum == '0 && y_sum == '0)
    else $error("window write did not clear history");

endmodule

FILE: design/dual_axis_moving_average.sv
// ----------------------------------------------------------------------------
// dual_axis_moving_average - moving mean of x/y position samples
// Keeps a ring of up to window_len samples per axis and gives, for every
// incoming sample pair, the mean of the held samples plus the new one.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pos       in   valid/ready    pos_x, pos_y   (signed Q8.8)
//  avg       out  valid/ready    avg_x, avg_y   (signed Q8.8)
//  cfg       in   cfg_we         cfg_data = window_len (4 bit)
//
//  The bit-serial divider gives one quotient bit per clock for both axes; a
//  new sample pair is taken only after the last mean is in the output register.
//  rst is synchronous: window_len returns to 4 and the history empties; the
//  ring contents are left as they are and only held entries are ever read.
//  A new pos transfer is taken while a finished mean still waits on avg;
//  a stalled avg only holds the next mean back once its divide is done.
//  A cfg write empties the history and is meant for when the block is idle.
// ----------------------------------------------------------------------------
module dual_axis_moving_average
  import dama_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  win_t        cfg_data,
  input  logic        cfg_we,
  dama_pos_if.sink    pos,
  dama_avg_if.source  avg
);

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  // ready comes from the sequencer: high only between samples
  assign pos.ready = in_ready;

  // sequencing: accumulate, load divider, SUM_W divide steps, retire, output
  dama_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pos.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // ring, sums, divider lanes and the output register
  dama_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .pos      (pos),
    .avg      (avg)
  );

endmodule
